>>> rtl/sc1a_pkg.sv
// ----------------------------------------------------------------------------
// sc1a_pkg - shared types and constants for the set-1 scancode decoder
// Operation codes, special key codes, decoder state and the two key ROMs.
// ----------------------------------------------------------------------------
package sc1a_pkg;

    localparam int FuncW = 3;
    localparam int ByteW = 8;
    localparam int CharW = 7;
    localparam int SpecW = 3;

    localparam logic [FuncW-1:0] FUNC_SCAN  = 3'd0;
    localparam logic [FuncW-1:0] FUNC_TAKE_CHAR = 3'd1;
    localparam logic [FuncW-1:0] FUNC_TAKE_SPEC = 3'd2;
    localparam logic [FuncW-1:0] FUNC_ACTIVATE  = 3'd3;
    localparam logic [FuncW-1:0] FUNC_DEACTIVATE = 3'd4;

    localparam logic [SpecW-1:0] SPEC_NONE  = 3'd0;
    localparam logic [SpecW-1:0] SPEC_UP    = 3'd1;
    localparam logic [SpecW-1:0] SPEC_DOWN  = 3'd2;
    localparam logic [SpecW-1:0] SPEC_LEFT  = 3'd3;
    localparam logic [SpecW-1:0] SPEC_RIGHT = 3'd4;

    localparam logic [ByteW-1:0] CODE_EXT     = 8'hE0;
    localparam logic [6:0]       KEY_LSHIFT   = 7'h2A;
    localparam logic [6:0]       KEY_RSHIFT   = 7'h36;
    localparam logic [6:0]       KEY_CAPS     = 7'h3A;
    localparam logic [6:0]       KEY_EXT_UP   = 7'h48;
    localparam logic [6:0]       KEY_EXT_DOWN = 7'h50;
    localparam logic [6:0]       KEY_EXT_LEFT = 7'h4B;
    localparam logic [6:0]       KEY_EXT_RIGHT = 7'h4D;
    localparam logic [CharW-1:0] CASE_OFFSET  = 7'd32;

    typedef struct packed {
        logic             ext;
        logic             en;
        logic             shift;
        logic             caps;
        logic [CharW-1:0] ch;
        logic [SpecW-1:0] spec;
    } dec_state_t;

    typedef struct packed {
        logic             en;
        logic             caps;
        logic             shift;
        logic [SpecW-1:0] spec;
        logic [CharW-1:0] ch;
    } dec_result_t;

    function automatic logic [CharW-1:0] rom_lower(input logic [6:0] key);
        logic [CharW-1:0] c;
        case (key)
            7'h01: c = 7'h1B; 7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33;
            7'h05: c = 7'h34; 7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37;
            7'h09: c = 7'h38; 7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D;
            7'h0D: c = 7'h3D; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
            7'h10: c = 7'h71; 7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72;
            7'h14: c = 7'h74; 7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69;
            7'h18: c = 7'h6F; 7'h19: c = 7'h70; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D;
            7'h1C: c = 7'h0A; 7'h1E: c = 7'h61; 7'h1F: c = 7'h73;
            7'h20: c = 7'h64; 7'h21: c = 7'h66; 7'h22: c = 7'h67; 7'h23: c = 7'h68;
            7'h24: c = 7'h6A; 7'h25: c = 7'h6B; 7'h26: c = 7'h6C; 7'h27: c = 7'h3B;
            7'h28: c = 7'h27; 7'h29: c = 7'h60; 7'h2B: c = 7'h5C;
            7'h2C: c = 7'h7A; 7'h2D: c = 7'h78; 7'h2E: c = 7'h63; 7'h2F: c = 7'h76;
            7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D; 7'h33: c = 7'h2C;
            7'h34: c = 7'h2E; 7'h35: c = 7'h2F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
            7'h4A: c = 7'h2D; 7'h4E: c = 7'h2B;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [CharW-1:0] rom_upper(input logic [6:0] key);
        logic [CharW-1:0] c;
        case (key)
            7'h01: c = 7'h1B; 7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23;
            7'h05: c = 7'h24; 7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26;
            7'h09: c = 7'h2A; 7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F;
            7'h0D: c = 7'h2B; 7'h0E: c = 7'h08; 7'h0F: c = 7'h09;
            7'h10: c = 7'h51; 7'h11: c = 7'h57; 7'h12: c = 7'h45; 7'h13: c = 7'h52;
            7'h14: c = 7'h54; 7'h15: c = 7'h59; 7'h16: c = 7'h55; 7'h17: c = 7'h49;
            7'h18: c = 7'h4F; 7'h19: c = 7'h50; 7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D;
            7'h1C: c = 7'h0A; 7'h1E: c = 7'h41; 7'h1F: c = 7'h53;
            7'h20: c = 7'h44; 7'h21: c = 7'h46; 7'h22: c = 7'h47; 7'h23: c = 7'h48;
            7'h24: c = 7'h4A; 7'h25: c = 7'h4B; 7'h26: c = 7'h4C; 7'h27: c = 7'h3A;
            7'h28: c = 7'h22; 7'h29: c = 7'h7E; 7'h2B: c = 7'h7C;
            7'h2C: c = 7'h5A; 7'h2D: c = 7'h58; 7'h2E: c = 7'h43; 7'h2F: c = 7'h56;
            7'h30: c = 7'h42; 7'h31: c = 7'h4E; 7'h32: c = 7'h4D; 7'h33: c = 7'h3C;
            7'h34: c = 7'h3E; 7'h35: c = 7'h3F; 7'h37: c = 7'h2A; 7'h39: c = 7'h20;
            7'h4A: c = 7'h2D; 7'h4E: c = 7'h2B;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/sc1a_decode.sv
// ----------------------------------------------------------------------------
// sc1a_decode - next-state and result logic for one operation
// Pure combinational step: current state and one operation in, next state
// and the reported result out.
// ----------------------------------------------------------------------------
module sc1a_decode
    import sc1a_pkg::*;
(
    input  dec_state_t        cur,
    input  logic [FuncW-1:0]  func,
    input  logic [ByteW-1:0]  scan_byte,
    output dec_state_t        nxt,
    output dec_result_t       res
);

    logic             brk;
    logic [6:0]       key;
    logic [CharW-1:0] lo_c;
    logic [CharW-1:0] up_c;
    logic [CharW-1:0] sel_c;
    dec_state_t       post;

    assign brk  = scan_byte[ByteW-1];
    assign key  = scan_byte[6:0];
    assign lo_c = rom_lower(key);
    assign up_c = rom_upper(key);

    always_comb
    begin
        sel_c = (cur.shift != cur.caps) ? up_c : lo_c;
        post  = cur;
        case (func)
            FUNC_SCAN:
            begin
                if (cur.en)
                begin
                    if (scan_byte == CODE_EXT)
                    begin
                        post.ext = 1'b1;
                    end
                    else
                    begin
                        post.ext = 1'b0;
                        if (!cur.ext)
                        begin
                            if (key == KEY_LSHIFT || key == KEY_RSHIFT)
                            begin
                                post.shift = !brk;
                            end
                            else if (key == KEY_CAPS)
                            begin
                                if (!brk)
                                begin
                                    post.caps = !cur.caps;
                                end
                            end
                            else if (!brk)
                            begin
                                if (cur.caps && !cur.shift)
                                begin
                                    // caps only: upper-case letters, store even a zero
                                    if (lo_c inside {[7'h61:7'h7A]})
                                    begin
                                        post.ch = lo_c - CASE_OFFSET;
                                    end
                                    else
                                    begin
                                        post.ch = lo_c;
                                    end
                                end
                                else if (sel_c != '0)
                                begin
                                    post.ch = sel_c;
                                end
                            end
                        end
                        else if (!brk)
                        begin
                            case (key)
                                KEY_EXT_UP:    post.spec = SPEC_UP;
                                KEY_EXT_DOWN:  post.spec = SPEC_DOWN;
                                KEY_EXT_LEFT:  post.spec = SPEC_LEFT;
                                KEY_EXT_RIGHT: post.spec = SPEC_RIGHT;
                                default:       post.spec = cur.spec;
                            endcase
                        end
                    end
                end
            end
            FUNC_ACTIVATE:
            begin
                post.en    = 1'b1;
                post.ext   = 1'b0;
                post.shift = 1'b0;
                post.caps  = 1'b0;
                post.ch    = '0;
                post.spec  = SPEC_NONE;
            end
            FUNC_DEACTIVATE:
            begin
                post.en = 1'b0;
            end
            default:
            begin
                post = cur;
            end
        endcase

        res.en    = post.en;
        res.caps  = post.caps;
        res.shift = post.shift;
        res.spec  = post.spec;
        res.ch    = post.ch;

        // take operations report the buffer, then clear it
        nxt = post;
        if (func == FUNC_TAKE_CHAR)
        begin
            nxt.ch = '0;
        end
        if (func == FUNC_TAKE_SPEC)
        begin
            nxt.spec = SPEC_NONE;
        end
    end

endmodule

>>> rtl/scancode_set1_to_ascii_decoder_unit.sv
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_decoder_unit - set-1 scancode to ASCII decoder
// Output: the result of each accepted word is held in a single output register.
// Throughput: one word per cycle; the single output register frees up in the
// same cycle its word is taken, so the input is stalled only by the output.
// Reset: asynchronous, clears all flags, buffers and the output valid.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_decoder_unit
    import sc1a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] scan_byte
    input  logic [2:0]  s_axis_tuser,   // [2:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [6:0] char_out, [9:7] special_out,
                                        // [10] shift_held, [11] caps_active,
                                        // [12] input_enabled, [15:13] zero
);

    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t res;
    logic        accept;
    logic        m_valid_reg;
    logic        m_valid_next;
    dec_result_t m_data_reg;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sc1a_decode u_decode (
        .cur       (state_reg),
        .func      (s_axis_tuser),
        .scan_byte (s_axis_tdata),
        .nxt       (state_next),
        .res       (res)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (accept)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    // hold the result word until it is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, m_data_reg};

endmodule
